### design/dcse_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and sobel helper for the depth/colour edge block
// no dependencies

package dcse_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int POS_W      = $clog2(MAX_WIDTH);   // column / row counter width
    localparam int DIM_W      = 12;                  // frame size register width
    localparam int DEPTH_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int DGRAD_W    = DEPTH_W + 2;         // |gx|, |gy| of depth
    localparam int CGRAD_W    = CHAN_W + 2;          // |gx|, |gy| of a colour channel
    localparam int DSQ_W      = 2 * DGRAD_W;
    localparam int CSQ_W      = 2 * CGRAD_W;
    localparam int DTHR_W     = 53;
    localparam int CTHR_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 53;

    localparam logic [DIM_W-1:0] DIM_MIN     = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX  = DIM_W'(MAX_HEIGHT);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_THR    = 3'd4;

    // edge mode codes
    localparam logic [1:0] MODE_DEPTH = 2'd1;
    localparam logic [1:0] MODE_COLOR = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    localparam logic [DTHR_W-1:0] DEPTH_THR_RESET = 53'd28147443984;
    localparam logic [CTHR_W-1:0] COLOR_THR_RESET = 21'd90000;
    localparam logic [DIM_W-1:0]  WIDTH_RESET     = 12'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 12'd480;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_value;
        logic [CHAN_W-1:0]  red_value;
        logic [CHAN_W-1:0]  green_value;
        logic [CHAN_W-1:0]  blue_value;
    } pixel_t;

    typedef struct packed {
        logic             center_valid;
        logic             is_edge;
        logic [POS_W-1:0] center_col;
        logic [POS_W-1:0] center_row;
    } result_t;

    typedef struct packed {
        logic [DGRAD_W-1:0] gx_abs;
        logic [DGRAD_W-1:0] gy_abs;
    } grad_t;

    // 3x3 window of one channel, entry r*3+c, values zero-extended to depth width
    typedef logic [8:0][DEPTH_W-1:0] win_chan_t;

    function automatic logic [DGRAD_W-1:0] abs_diff(input logic [DGRAD_W-1:0] a,
                                                    input logic [DGRAD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic grad_t sobel_abs(input win_chan_t v);
        logic [DGRAD_W-1:0] xp, xn, yp, yn;
        grad_t g;
        xp = DGRAD_W'(v[2]) + {1'b0, v[5], 1'b0} + DGRAD_W'(v[8]);
        xn = DGRAD_W'(v[0]) + {1'b0, v[3], 1'b0} + DGRAD_W'(v[6]);
        yp = DGRAD_W'(v[6]) + {1'b0, v[7], 1'b0} + DGRAD_W'(v[8]);
        yn = DGRAD_W'(v[0]) + {1'b0, v[1], 1'b0} + DGRAD_W'(v[2]);
        g.gx_abs = abs_diff(xp, xn);
        g.gy_abs = abs_diff(yp, yn);
        return g;
    endfunction

endpackage

### design/depth_color_sobel_edges.sv
`timescale 1ns / 1ps
// 3x3 sobel edge marker on a raster stream of depth and rgb pixels
// depends on dcse_pkg

// Takes one pixel per clock while pixel_stall is low and returns one result per pixel; a pixel
// passes the stage 1, stage 2, stage 3 and output registers before result_valid rises for it, and the result
// describes the pixel one row and one column back. Two 2048-entry line stores are each read once per
// pixel on the beat and written once when that pixel leaves the first stage; behind them a gradient
// stage, a squaring stage and the compare/output register follow, each holding one pixel. A result
// with center_valid low comes for pixels in column 0 or row 0. The user must write configuration only
// while no pixel is in flight; the block does not enforce this. Frame geometry is clamped to 3..2048.
module depth_color_sobel_edges (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  dcse_pkg::pixel_t               pixel,
    output logic                           result_valid,
    input  logic                           result_stall,
    output dcse_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dcse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcse_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dcse_pkg::*;

    // configuration
    logic [1:0]        edge_mode_reg;
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [DTHR_W-1:0] depth_thr_reg;
    logic [CTHR_W-1:0] color_thr_reg;
    logic [DIM_W-1:0]  width_eff;
    logic [DIM_W-1:0]  height_eff;

    // position counters
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    // line stores
    pixel_t upper_mem  [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];
    pixel_t upper_rd_reg;
    pixel_t middle_rd_reg;

    // stage 1: input pixel
    logic             s1_valid_reg;
    pixel_t           s1_pixel_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic [POS_W-1:0] s1_row_reg;

    pixel_t window_reg [6];

    // stage 2: gradient magnitudes
    logic               s2_valid_reg;
    logic               s2_ctr_reg;
    logic               s2_test_reg;
    logic [POS_W-1:0]   s2_col_reg;
    logic [POS_W-1:0]   s2_row_reg;
    grad_t              s2_depth_reg;
    logic [CGRAD_W-1:0] s2_cgx_reg [3];
    logic [CGRAD_W-1:0] s2_cgy_reg [3];

    // stage 3: squares
    logic             s3_valid_reg;
    logic             s3_ctr_reg;
    logic             s3_test_reg;
    logic [POS_W-1:0] s3_col_reg;
    logic [POS_W-1:0] s3_row_reg;
    logic [DSQ_W-1:0] s3_dx_sq_reg;
    logic [DSQ_W-1:0] s3_dy_sq_reg;
    logic [CSQ_W-1:0] s3_cx_sq_reg [3];
    logic [CSQ_W-1:0] s3_cy_sq_reg [3];

    // output
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic accept;
    logic out_free, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free;

    // --- handshake chain
    assign out_free    = !out_valid_reg || !result_stall;
    assign s3_move     = s3_valid_reg && out_free;
    assign s3_free     = !s3_valid_reg || s3_move;
    assign s2_move     = s2_valid_reg && s3_free;
    assign s2_free     = !s2_valid_reg || s2_move;
    assign s1_move     = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s1_move;
    assign pixel_stall = !s1_free;
    assign accept      = pixel_valid && s1_free;
    assign cfg_ready   = 1'b1;

    // --- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_mode_reg    <= MODE_BOTH;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            depth_thr_reg    <= DEPTH_THR_RESET;
            color_thr_reg    <= COLOR_THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EDGE_MODE:    edge_mode_reg    <= cfg_data[1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                CFG_DEPTH_THR:    depth_thr_reg    <= cfg_data[DTHR_W-1:0];
                CFG_COLOR_THR:    color_thr_reg    <= cfg_data[CTHR_W-1:0];
                default:          ;
            endcase
        end
    end

    assign width_eff  = (frame_width_reg < DIM_MIN) ? DIM_MIN :
                        (frame_width_reg > WIDTH_MAX) ? WIDTH_MAX : frame_width_reg;
    assign height_eff = (frame_height_reg < DIM_MIN) ? DIM_MIN :
                        (frame_height_reg > HEIGHT_MAX) ? HEIGHT_MAX : frame_height_reg;

    // --- raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if ({1'b0, col_reg} + DIM_W'(1) >= width_eff)
            begin
                col_next = '0;
                row_next = ({1'b0, row_reg} + DIM_W'(1) >= height_eff) ? '0
                                                                       : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // --- line stores: read on the input beat, written when the pixel leaves stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (s1_move)
        begin
            upper_mem[s1_col_reg]  <= middle_rd_reg;
            middle_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    // --- stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
    end

    // --- 3x3 window: left two columns in registers, right column from stores and input
    pixel_t    win [9];
    win_chan_t win_depth, win_red, win_green, win_blue;
    grad_t     g_depth, g_red, g_green, g_blue;
    logic      s1_ctr, s1_test;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win[r*3]     = window_reg[r];
            win[r*3 + 1] = window_reg[3 + r];
        end
        win[2] = upper_rd_reg;
        win[5] = middle_rd_reg;
        win[8] = s1_pixel_reg;
        for (int k = 0; k < 9; k++)
        begin
            win_depth[k] = win[k].depth_value;
            win_red[k]   = DEPTH_W'(win[k].red_value);
            win_green[k] = DEPTH_W'(win[k].green_value);
            win_blue[k]  = DEPTH_W'(win[k].blue_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
                window_reg[k] <= '0;
        end
        else if (s1_move)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r]     <= win[r*3 + 1];
                window_reg[3 + r] <= win[r*3 + 2];
            end
        end
    end

    assign g_depth = sobel_abs(win_depth);
    assign g_red   = sobel_abs(win_red);
    assign g_green = sobel_abs(win_green);
    assign g_blue  = sobel_abs(win_blue);

    assign s1_ctr  = (s1_col_reg != '0) && (s1_row_reg != '0);
    // border and out-of-frame centres are never tested
    assign s1_test = s1_ctr && (s1_col_reg >= POS_W'(2)) && (s1_row_reg >= POS_W'(2))
                     && ({1'b0, s1_col_reg} < width_eff) && ({1'b0, s1_row_reg} < height_eff);

    // --- stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_ctr_reg    <= s1_ctr;
            s2_test_reg   <= s1_test;
            s2_col_reg    <= s1_ctr ? s1_col_reg - 1'b1 : '0;
            s2_row_reg    <= s1_ctr ? s1_row_reg - 1'b1 : '0;
            s2_depth_reg  <= g_depth;
            s2_cgx_reg[0] <= g_red.gx_abs[CGRAD_W-1:0];
            s2_cgy_reg[0] <= g_red.gy_abs[CGRAD_W-1:0];
            s2_cgx_reg[1] <= g_green.gx_abs[CGRAD_W-1:0];
            s2_cgy_reg[1] <= g_green.gy_abs[CGRAD_W-1:0];
            s2_cgx_reg[2] <= g_blue.gx_abs[CGRAD_W-1:0];
            s2_cgy_reg[2] <= g_blue.gy_abs[CGRAD_W-1:0];
        end
    end

    // --- stage 3 registers: squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_free)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_ctr_reg   <= s2_ctr_reg;
            s3_test_reg  <= s2_test_reg;
            s3_col_reg   <= s2_col_reg;
            s3_row_reg   <= s2_row_reg;
            s3_dx_sq_reg <= DSQ_W'(s2_depth_reg.gx_abs) * DSQ_W'(s2_depth_reg.gx_abs);
            s3_dy_sq_reg <= DSQ_W'(s2_depth_reg.gy_abs) * DSQ_W'(s2_depth_reg.gy_abs);
            for (int c = 0; c < 3; c++)
            begin
                s3_cx_sq_reg[c] <= CSQ_W'(s2_cgx_reg[c]) * CSQ_W'(s2_cgx_reg[c]);
                s3_cy_sq_reg[c] <= CSQ_W'(s2_cgy_reg[c]) * CSQ_W'(s2_cgy_reg[c]);
            end
        end
    end

    // --- sum, threshold compare, result
    logic [DTHR_W-1:0] depth_mag;
    logic [CTHR_W-1:0] color_mag [3];
    logic              depth_en, color_en, depth_hit, color_hit;

    always_comb
    begin
        depth_en  = (edge_mode_reg != MODE_COLOR);
        color_en  = (edge_mode_reg >= MODE_COLOR);
        depth_mag = DTHR_W'(s3_dx_sq_reg) + DTHR_W'(s3_dy_sq_reg);
        depth_hit = depth_mag > depth_thr_reg;
        color_hit = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            color_mag[c] = CTHR_W'(s3_cx_sq_reg[c]) + CTHR_W'(s3_cy_sq_reg[c]);
            if (color_mag[c] > color_thr_reg)
                color_hit = 1'b1;
        end
        out_next.center_valid = s3_ctr_reg;
        out_next.is_edge      = s3_test_reg && ((depth_en && depth_hit) ||
                                                (color_en && color_hit));
        out_next.center_col   = s3_col_reg;
        out_next.center_row   = s3_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_move)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### sim/depth_color_sobel_edges_test.sv
`timescale 1ns / 1ps
// self-checking bench for the depth/colour sobel edge marker: random frames, geometry and modes
// depends on dcse_pkg and depth_color_sobel_edges

module depth_color_sobel_edges_test;

    import dcse_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int RANDOM_PIXELS = 1000;
    localparam int WIDE_PIXELS = 120;
    localparam int TALL_PIXELS = 240;

    // edge_mode 0 is not a named mode but behaves as depth only
    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_LIST [4] = '{MODE_ZERO, MODE_DEPTH, MODE_COLOR, MODE_BOTH};
    // index past the last register, the block ignores it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {CH_DEPTH, CH_RED, CH_GREEN, CH_BLUE} chan_e;
    typedef enum int {SCENE_NOISE, SCENE_BLOCKS, SCENE_STEP, SCENE_SATURATED} scene_e;
    typedef pixel_t patch_t [3][3];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    pixel_t pixel = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    depth_color_sobel_edges dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    pixel_t pixel_backlog [$];
    result_t center_reports [$];

    // shadow of the block: line stores, window columns, raster position, registers
    pixel_t upper_row [MAX_WIDTH];
    pixel_t middle_row [MAX_WIDTH];
    pixel_t win_cols [6] = '{default: '0};
    int col_pos = 0;
    int row_pos = 0;
    logic [1:0] mode_reg = MODE_BOTH;
    logic [DIM_W-1:0] width_reg = WIDTH_RESET;
    logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
    logic [DTHR_W-1:0] depth_thr = DEPTH_THR_RESET;
    logic [CTHR_W-1:0] color_thr = COLOR_THR_RESET;

    int pixels_pushed = 0;
    int pixels_taken = 0;
    int reports_checked = 0;
    int edges_seen = 0;
    int fail_count = 0;
    int settings_applied = 0;
    int stuck_cycles = 0;
    int send_gap = 0;
    int send_calm = 0;
    int hold_left = 0;
    int recv_calm = 0;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint chan_value(input pixel_t p, input chan_e ch);
        case (ch)
            CH_DEPTH: return longint'(p.depth_value);
            CH_RED:   return longint'(p.red_value);
            CH_GREEN: return longint'(p.green_value);
            default:  return longint'(p.blue_value);
        endcase
    endfunction

    function automatic longint sobel_energy(input patch_t nb, input chan_e ch);
        longint v [3][3];
        longint gx, gy;
        int r, c;
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                v[r][c] = chan_value(nb[r][c], ch);
        gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
        gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
        return gx * gx + gy * gy;
    endfunction

    // advances the shadow by one pixel and returns the report it causes
    function automatic result_t classify_pixel(input pixel_t px);
        int w, h, col, row, slot, r;
        pixel_t top, mid;
        patch_t nb;
        logic hit;
        result_t res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        col = col_pos;
        row = row_pos;
        slot = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
        top = upper_row[slot];
        mid = middle_row[slot];
        upper_row[slot] = mid;
        middle_row[slot] = px;
        for (r = 0; r < 3; r++)
        begin
            nb[r][0] = win_cols[r];
            nb[r][1] = win_cols[3 + r];
        end
        nb[0][2] = top;
        nb[1][2] = mid;
        nb[2][2] = px;

        res = '0;
        hit = 1'b0;
        if (col >= 1 && row >= 1)
        begin
            res.center_valid = 1'b1;
            res.center_col = POS_W'(col - 1);
            res.center_row = POS_W'(row - 1);
            // borders and counters past a shrunk frame never mark
            if (col >= 2 && row >= 2 && col < w && row < h)
            begin
                if (mode_reg != MODE_COLOR && sobel_energy(nb, CH_DEPTH) > longint'(depth_thr))
                    hit = 1'b1;
                if (mode_reg == MODE_COLOR || mode_reg == MODE_BOTH)
                begin
                    if (sobel_energy(nb, CH_RED) > longint'(color_thr))
                        hit = 1'b1;
                    if (sobel_energy(nb, CH_GREEN) > longint'(color_thr))
                        hit = 1'b1;
                    if (sobel_energy(nb, CH_BLUE) > longint'(color_thr))
                        hit = 1'b1;
                end
            end
        end
        res.is_edge = hit;

        for (r = 0; r < 3; r++)
        begin
            win_cols[r] = nb[r][1];
            win_cols[3 + r] = nb[r][2];
        end
        if (col + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end
        else
        begin
            col_pos = col + 1;
        end
        return res;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_EDGE_MODE:    mode_reg = v[1:0];
            CFG_FRAME_WIDTH:  width_reg = v[DIM_W-1:0];
            CFG_FRAME_HEIGHT: height_reg = v[DIM_W-1:0];
            CFG_DEPTH_THR:    depth_thr = v[DTHR_W-1:0];
            CFG_COLOR_THR:    color_thr = v[CTHR_W-1:0];
            default: ;
        endcase
    endfunction

    // pixels still needed to bring the raster position back to the frame start
    function automatic int pixels_to_frame_start();
        int c, r, w, h, n;
        c = col_pos;
        r = row_pos;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        n = 0;
        while (c != 0 || r != 0)
        begin
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                c = c + 1;
            end
            n++;
        end
        return n;
    endfunction

    function automatic int gap_length(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // random bits above the register width, the register keeps only its own
    function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] field,
                                                         input int bits);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << bits) - 1'b1;
        return (CFG_DATA_W'({$urandom, $urandom}) & ~keep) | (field & keep);
    endfunction

    function automatic logic [DTHR_W-1:0] pick_depth_thr();
        longint unsigned r;
        r = {$urandom, $urandom};
        return DTHR_W'(r >> $urandom_range(11, 63));
    endfunction

    function automatic logic [CTHR_W-1:0] pick_color_thr();
        return CTHR_W'($urandom >> $urandom_range(11, 31));
    endfunction

    function automatic pixel_t noise_pixel();
        pixel_t px;
        px.depth_value = DEPTH_W'($urandom);
        px.red_value = CHAN_W'($urandom);
        px.green_value = CHAN_W'($urandom);
        px.blue_value = CHAN_W'($urandom);
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] mismatch on %s at report %0d: got %0d, expected %0d",
                     $time, what, reports_checked, got, want);
    endtask

    task automatic check_report(input result_t got);
        result_t want;
        if (center_reports.size() == 0)
        begin
            report_mismatch("report with none outstanding", longint'(got), 0);
            return;
        end
        want = center_reports.pop_front();
        reports_checked++;
        if (want.is_edge)
            edges_seen++;
        if (got.center_valid !== want.center_valid)
            report_mismatch("center_valid", got.center_valid, want.center_valid);
        if (got.is_edge !== want.is_edge)
            report_mismatch("is_edge", got.is_edge, want.is_edge);
        if (got.center_col !== want.center_col)
            report_mismatch("center_col", got.center_col, want.center_col);
        if (got.center_row !== want.center_row)
            report_mismatch("center_row", got.center_row, want.center_row);
    endtask

    task automatic push_pixel(input pixel_t px);
        pixel_backlog.push_back(px);
        pixels_pushed++;
    endtask

    task automatic wait_idle();
        while (pixels_taken != pixels_pushed || center_reports.size() != 0)
            @(posedge clk);
    endtask

    // flat regions split by steps, noise, or saturated fields
    task automatic queue_scene(input int count, input int w);
        int n, c, r, step_c, step_r;
        scene_e style;
        pixel_t lo, hi, px;
        style = scene_e'($urandom_range(0, 3));
        step_c = $urandom_range(1, w);
        step_r = $urandom_range(1, 6);
        lo = noise_pixel();
        hi = noise_pixel();
        for (n = 0; n < count; n++)
        begin
            c = n % w;
            r = n / w;
            case (style)
                SCENE_NOISE:
                    px = noise_pixel();
                SCENE_BLOCKS:
                    px = ((c >= step_c) != (r % 8 >= step_r)) ? hi : lo;
                SCENE_STEP:
                begin
                    px = (c >= step_c) ? hi : lo;
                    px.depth_value = px.depth_value ^ DEPTH_W'($urandom_range(0, 15));
                    px.green_value = px.green_value ^ CHAN_W'($urandom_range(0, 3));
                end
                default:
                begin
                    px.depth_value = $urandom_range(0, 1) ? '1 : '0;
                    px.red_value = $urandom_range(0, 1) ? '1 : '0;
                    px.green_value = $urandom_range(0, 1) ? '1 : '0;
                    px.blue_value = $urandom_range(0, 1) ? '1 : '0;
                end
            endcase
            push_pixel(px);
        end
    endtask

    task automatic configure(input logic [1:0] mode, input logic [DIM_W-1:0] wr,
                             input logic [DIM_W-1:0] hr, input logic [DTHR_W-1:0] dthr,
                             input logic [CTHR_W-1:0] cthr, input bit stray);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        int i, count;
        wait_idle();
        idx[0] = CFG_EDGE_MODE;
        val[0] = with_noise(CFG_DATA_W'(mode), 2);
        idx[1] = CFG_FRAME_WIDTH;
        val[1] = with_noise(CFG_DATA_W'(wr), DIM_W);
        idx[2] = CFG_FRAME_HEIGHT;
        val[2] = with_noise(CFG_DATA_W'(hr), DIM_W);
        idx[3] = CFG_DEPTH_THR;
        val[3] = with_noise(CFG_DATA_W'(dthr), DTHR_W);
        idx[4] = CFG_COLOR_THR;
        val[4] = with_noise(CFG_DATA_W'(cthr), CTHR_W);
        idx[5] = CFG_UNUSED;
        val[5] = CFG_DATA_W'({$urandom, $urandom});
        count = stray ? 6 : 5;
        for (i = 0; i < count; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            apply_register(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                center_reports.push_back(classify_pixel(pixel));
                pixels_taken++;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_gap > 0)
                begin
                    pixel_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    pixel <= pixel_backlog.pop_front();
                    pixel_valid <= 1'b1;
                    send_gap <= gap_length(send_calm > 0);
                    if (send_calm > 0)
                        send_calm <= send_calm - 1;
                    else if ($urandom_range(0, 99) < 3)
                        send_calm <= $urandom_range(30, 150);
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // report monitor with random backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_report(result);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                hold_left <= gap_length(recv_calm > 0);
                if (recv_calm > 0)
                    recv_calm <= recv_calm - 1;
                else if ($urandom_range(0, 99) < 2)
                    recv_calm <= $urandom_range(40, 160);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("[%0t] no beat for %0d cycles, %0d reports outstanding",
                 $time, STUCK_LIMIT, center_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int p, n, w, h, k, frames, random_pixels;
        logic [1:0] mode;
        logic [DIM_W-1:0] wr, hr;
        logic [DTHR_W-1:0] dthr;
        logic [CTHR_W-1:0] cthr;
        pixel_t px;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small frame with saturated fields: row/frame starts, borders, steps in every channel
        configure(MODE_BOTH, DIM_W'(5), DIM_W'(5), DEPTH_THR_RESET, COLOR_THR_RESET, 1'b0);
        for (n = 0; n < 25; n++)
        begin
            px.depth_value = (n % 5 >= 3) ? '1 : '0;
            px.red_value = (n / 5 >= 3) ? '1 : '0;
            px.green_value = ((n % 5 + n / 5) % 2 == 1) ? '1 : '0;
            px.blue_value = CHAN_W'((n % 5) * 60 + n / 5);
            push_pixel(px);
        end

        random_pixels = 0;
        p = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            mode = (p < 4) ? MODE_LIST[p] : MODE_LIST[$urandom_range(0, 3)];
            if (p == 0)
            begin
                wr = DIM_W'(0);
                hr = DIM_W'(1);
            end
            else if (p == 1)
            begin
                wr = DIM_W'(2);
                hr = DIM_W'(0);
            end
            else
            begin
                wr = ($urandom_range(0, 99) < 6) ? DIM_W'($urandom_range(0, 2))
                                                 : DIM_W'($urandom_range(3, 14));
                hr = ($urandom_range(0, 99) < 6) ? DIM_W'($urandom_range(0, 2))
                                                 : DIM_W'($urandom_range(3, 9));
            end
            if (p == 2)
            begin
                dthr = '0;
                cthr = '0;
            end
            else if (p == 3)
            begin
                dthr = '1;
                cthr = '1;
            end
            else
            begin
                dthr = pick_depth_thr();
                cthr = pick_color_thr();
            end
            configure(mode, wr, hr, dthr, cthr, p == 1);
            w = clamp_dim(wr, MAX_WIDTH);
            h = clamp_dim(hr, MAX_HEIGHT);
            frames = $urandom_range(1, 2);
            queue_scene(frames * w * h, w);
            random_pixels += frames * w * h;

            // stop inside a frame, shrink the geometry, then run out to the next frame start
            if ($urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(2 * w, w * h - 1);
                queue_scene(k, w);
                random_pixels += k;
                configure(mode, DIM_W'($urandom_range(3, w)), DIM_W'($urandom_range(3, h)),
                          dthr, cthr, 1'b0);
                k = pixels_to_frame_start();
                queue_scene(k, clamp_dim(width_reg, MAX_WIDTH));
                random_pixels += k;
            end
            p++;
        end

        // widest frame requested past the clamp limit, then a narrow frame whose height is;
        // short runs show that neither counter wraps early
        configure(MODE_LIST[$urandom_range(0, 3)], '1, DIM_W'(0),
                  pick_depth_thr(), pick_color_thr(), 1'b0);
        queue_scene(WIDE_PIXELS, MAX_WIDTH);
        configure(MODE_LIST[$urandom_range(0, 3)], DIM_W'(1), '1,
                  pick_depth_thr(), pick_color_thr(), 1'b0);
        queue_scene(TALL_PIXELS, 3);

        wait_idle();
        repeat (12) @(posedge clk);
        $display("run covered %0d pixels over %0d register settings, including clamped and",
                 pixels_taken, settings_applied);
        $display("mid-frame shrunk geometry; %0d reports checked, %0d marked as edges",
                 reports_checked, edges_seen);
        if (fail_count == 0 && center_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
design/dcse_pkg.sv
design/depth_color_sobel_edges.sv
sim/depth_color_sobel_edges_test.sv
